// ===== rtl/box_downsample_2x2_macros.svh =====
// ----------------------------------------------------------------------------
// box_downsample_2x2 assertion macros
// shorthand for clocked concurrent assertions in the checker
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_MACROS_SVH

// checked outside reset only
`define BDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked through reset as well
`define BDS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bds2x2_pkg.sv =====
// ----------------------------------------------------------------------------
// bds2x2_pkg
// shared constants, types and helpers of the 2x2 box downsampler
// ----------------------------------------------------------------------------
package bds2x2_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int MAX_CHANNELS = 4;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int SLOT_W       = $clog2(LINE_DEPTH);
  localparam int POS_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);

  localparam int CFG_W    = 12;
  localparam int CH_CFG_W = 3;
  localparam int REG_W    = 2;
  localparam int SAMPLE_W = 8;
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int SUM_W    = SAMPLE_W + 2;

  localparam logic [REG_W-1:0] REG_WIDTH         = 2'd0;
  localparam logic [REG_W-1:0] REG_HEIGHT        = 2'd1;
  localparam logic [REG_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [CFG_W-1:0]    RESET_WIDTH    = 12'd640;
  localparam logic [CFG_W-1:0]    RESET_HEIGHT   = 12'd480;
  localparam logic [CH_CFG_W-1:0] RESET_CHANNELS = 3'd3;

  typedef logic [SAMPLE_W-1:0]           sample_t;
  typedef logic [PAIR_W-1:0]             pair_t;
  typedef pair_t   [MAX_CHANNELS-1:0]    pair_vec_t;
  typedef sample_t [MAX_CHANNELS-1:0]    sample_vec_t;

  typedef struct packed {
    logic                    valid;
    logic                    frame_end;
    logic [MAX_CHANNELS-1:0] ch_en;
  } stage_ctl_t;

  // zero acts as one, anything above the limit saturates
  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

// ===== rtl/bds2x2_stream_if.sv =====
// ----------------------------------------------------------------------------
// bds2x2 stream interfaces
// valid/ready channels for input pixels and output mean words
// ----------------------------------------------------------------------------
interface bds2x2_pixel_if;
  logic                     valid;
  logic                     ready;
  bds2x2_pkg::sample_t      sample_ch0;
  bds2x2_pkg::sample_t      sample_ch1;
  bds2x2_pkg::sample_t      sample_ch2;
  bds2x2_pkg::sample_t      sample_ch3;

  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                output ready);
endinterface

interface bds2x2_mean_if;
  logic                     valid;
  logic                     ready;
  bds2x2_pkg::sample_t      mean_ch0;
  bds2x2_pkg::sample_t      mean_ch1;
  bds2x2_pkg::sample_t      mean_ch2;
  bds2x2_pkg::sample_t      mean_ch3;
  logic                     frame_end;

  modport source (output valid, mean_ch0, mean_ch1, mean_ch2, mean_ch3, frame_end,
                  input ready);
  modport sink (input valid, mean_ch0, mean_ch1, mean_ch2, mean_ch3, frame_end,
                output ready);
endinterface

// ===== rtl/box_downsample_2x2.sv =====
// ----------------------------------------------------------------------------
// box_downsample_2x2: 2x2 box-filter downsampler, half-size raster output
// path: the right pixel of an odd row goes through the pair stage, then the output word register
// throughput: one pixel per cycle while the output is not stalled
// reset: clears position and valid flags, registers back to 640x480, 3 ch
// ----------------------------------------------------------------------------
module box_downsample_2x2 (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bds2x2_pkg::REG_W-1:0]         cfg_index,
  input  logic [bds2x2_pkg::CFG_W-1:0]         cfg_data,
  bds2x2_pixel_if.sink                         pixels,
  bds2x2_mean_if.source                        means
);

  localparam int CW = bds2x2_pkg::CFG_W;
  localparam int NC = bds2x2_pkg::MAX_CHANNELS;

  logic [CW-1:0]                     width_cfg;
  logic [CW-1:0]                     height_cfg;
  logic [bds2x2_pkg::CH_CFG_W-1:0]   channel_count;

  logic [bds2x2_pkg::POS_W-1:0]      column_position;
  logic [bds2x2_pkg::ROW_W-1:0]      row_position;
  logic [bds2x2_pkg::POS_W-1:0]      column_position_next;
  logic [bds2x2_pkg::ROW_W-1:0]      row_position_next;
  bds2x2_pkg::sample_vec_t           held_left;

  bds2x2_pkg::pair_vec_t             line_mem [bds2x2_pkg::LINE_DEPTH];
  bds2x2_pkg::pair_vec_t             line_rd;

  bds2x2_pkg::stage_ctl_t            p_ctl;
  bds2x2_pkg::pair_vec_t             p_pair;
  logic                              o_valid;
  logic                              o_frame_end;
  bds2x2_pkg::sample_vec_t           o_mean;

  logic [CW-1:0]                     w, h, nch, even_w, even_h;
  logic [CW-1:0]                     col, row, col_inc, row_inc;
  logic [bds2x2_pkg::SLOT_W-1:0]     slot;
  bds2x2_pkg::sample_vec_t           smp;
  bds2x2_pkg::pair_vec_t             pair;
  logic [NC-1:0]                     ch_en;
  logic                              accept, in_pair, do_write, do_read, frame_end_n;
  logic                              p_ready, p_move;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg     <= bds2x2_pkg::RESET_WIDTH;
      height_cfg    <= bds2x2_pkg::RESET_HEIGHT;
      channel_count <= bds2x2_pkg::RESET_CHANNELS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bds2x2_pkg::REG_WIDTH:         width_cfg     <= cfg_data;
        bds2x2_pkg::REG_HEIGHT:        height_cfg    <= cfg_data;
        bds2x2_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[bds2x2_pkg::CH_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w      = bds2x2_pkg::clamp_cfg(width_cfg, CW'(bds2x2_pkg::MAX_WIDTH));
    h      = bds2x2_pkg::clamp_cfg(height_cfg, CW'(bds2x2_pkg::MAX_HEIGHT));
    nch    = bds2x2_pkg::clamp_cfg(CW'(channel_count), CW'(NC));
    even_w = {w[CW-1:1], 1'b0};
    even_h = {h[CW-1:1], 1'b0};

    // position of this pixel, wrapped if a register change left it outside
    col = CW'(column_position);
    row = CW'(row_position);
    if (col >= w) begin
      col = '0;
      row = row + CW'(1);
    end
    if (row >= h) begin
      row = '0;
    end

    // position of the next pixel
    col_inc = col + CW'(1);
    row_inc = row;
    if (col_inc >= w) begin
      col_inc = '0;
      row_inc = row + CW'(1);
      if (row_inc >= h) begin
        row_inc = '0;
      end
    end
    column_position_next = col_inc[bds2x2_pkg::POS_W-1:0];
    row_position_next    = row_inc[bds2x2_pkg::ROW_W-1:0];

    slot = col[bds2x2_pkg::SLOT_W:1];
    smp  = {pixels.sample_ch3, pixels.sample_ch2, pixels.sample_ch1, pixels.sample_ch0};
    for (int c = 0; c < NC; c++) begin
      pair[c]  = bds2x2_pkg::PAIR_W'(held_left[c]) + bds2x2_pkg::PAIR_W'(smp[c]);
      ch_en[c] = (CW'(c) < nch);
    end

    accept      = pixels.valid && p_ready;
    in_pair     = col[0] && (col < even_w);
    do_write    = accept && in_pair && !row[0];
    do_read     = accept && in_pair && row[0] && (row < even_h);
    frame_end_n = (col == even_w - CW'(1)) && (row == even_h - CW'(1));
  end

  assign p_move       = p_ctl.valid && (!o_valid || means.ready);
  assign p_ready      = !p_ctl.valid || !o_valid || means.ready;
  assign pixels.ready = p_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (accept) begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !col[0]) begin
      held_left <= smp;
    end
  end

  // line buffer of even-row pair sums
  always_ff @(posedge clk) begin
    if (do_write) begin
      line_mem[slot] <= pair;
    end
    if (do_read) begin
      line_rd <= line_mem[slot];
    end
  end

  // stage holding the odd-row pair sum while the line entry is read
  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl.valid <= 1'b0;
    end else if (p_ready) begin
      p_ctl.valid <= do_read;
    end
    if (do_read) begin
      p_ctl.frame_end <= frame_end_n;
      p_ctl.ch_en     <= ch_en;
      p_pair          <= pair;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (!o_valid || means.ready) begin
      o_valid <= p_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_frame_end <= p_ctl.frame_end;
      for (int c = 0; c < NC; c++) begin
        logic [bds2x2_pkg::SUM_W-1:0] s;
        s = bds2x2_pkg::SUM_W'(line_rd[c]) + bds2x2_pkg::SUM_W'(p_pair[c]);
        o_mean[c] <= p_ctl.ch_en[c] ? s[bds2x2_pkg::SUM_W-1:2] : '0;
      end
    end
  end

  assign means.valid     = o_valid;
  assign means.mean_ch0  = o_mean[0];
  assign means.mean_ch1  = o_mean[1];
  assign means.mean_ch2  = o_mean[2];
  assign means.mean_ch3  = o_mean[3];
  assign means.frame_end = o_frame_end;

endmodule

// ===== rtl/bds2x2_checker.sv =====
// ----------------------------------------------------------------------------
// bds2x2_checker
// port-level checks of the 2x2 box downsampler, bound to the top level
// ----------------------------------------------------------------------------
`include "box_downsample_2x2_macros.svh"

module bds2x2_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_write,
  input logic [bds2x2_pkg::REG_W-1:0]   cfg_index,
  input logic [bds2x2_pkg::CFG_W-1:0]   cfg_data,
  input logic                           pixels_valid,
  input logic                           pixels_ready,
  input logic                           means_valid,
  input logic                           means_ready,
  input bds2x2_pkg::sample_t            mean_ch0,
  input bds2x2_pkg::sample_t            mean_ch1,
  input bds2x2_pkg::sample_t            mean_ch2,
  input bds2x2_pkg::sample_t            mean_ch3,
  input logic                           frame_end
);

  logic [bds2x2_pkg::CH_CFG_W-1:0] chan_shadow;
  logic [bds2x2_pkg::CFG_W-1:0]    nch;

  // copy of the channel count as written on the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_shadow <= bds2x2_pkg::RESET_CHANNELS;
    end else if (cfg_write && cfg_index == bds2x2_pkg::REG_CHANNEL_COUNT) begin
      chan_shadow <= cfg_data[bds2x2_pkg::CH_CFG_W-1:0];
    end
  end

  assign nch = bds2x2_pkg::clamp_cfg(bds2x2_pkg::CFG_W'(chan_shadow),
                                     bds2x2_pkg::CFG_W'(bds2x2_pkg::MAX_CHANNELS));

  `BDS_ASSERT_RST(a_reset_empty, rst |=> !means_valid, "output valid after reset")

  `BDS_ASSERT(a_out_hold, means_valid && !means_ready |=> means_valid && $stable(mean_ch0) && $stable(mean_ch1) && $stable(mean_ch2) && $stable(mean_ch3) && $stable(frame_end), "stalled output word changed")

  `BDS_ASSERT(a_latency, $rose(means_valid) |-> $past(pixels_valid && pixels_ready, 2), "output word without a pixel two cycles before")

  `BDS_ASSERT(a_unused_zero, means_valid |-> (nch >= 12'd2 || mean_ch1 == '0) && (nch >= 12'd3 || mean_ch2 == '0) && (nch >= 12'd4 || mean_ch3 == '0), "unused channel not zero")

endmodule

bind box_downsample_2x2 bds2x2_checker u_bds2x2_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_write    (cfg_write),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data),
  .pixels_valid (pixels.valid),
  .pixels_ready (pixels.ready),
  .means_valid  (means.valid),
  .means_ready  (means.ready),
  .mean_ch0     (means.mean_ch0),
  .mean_ch1     (means.mean_ch1),
  .mean_ch2     (means.mean_ch2),
  .mean_ch3     (means.mean_ch3),
  .frame_end    (means.frame_end)
);

// ===== bench/bds2x2_checker.sv =====
// ----------------------------------------------------------------------------
// bds2x2_scoreboard
// watches the pixel and mean channels of the 2x2 box downsampler, works out
// the expected mean words from its own copy of position, line sums and
// registers, and compares every word leaving the block in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bds2x2_scoreboard
  import bds2x2_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [REG_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  bds2x2_pixel_if          pixels,
  bds2x2_mean_if           means,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    sample_vec_t mean;
    logic        frame_end;
  } mean_word_t;

  mean_word_t expected_means[$];

  logic [CFG_W-1:0]    width_reg;
  logic [CFG_W-1:0]    height_reg;
  logic [CH_CFG_W-1:0] chan_reg;

  pair_vec_t   line_sums [LINE_DEPTH];
  sample_vec_t held_left;
  int unsigned col_pos;
  int unsigned row_pos;

  function automatic int unsigned limit_size(input int unsigned v, input int unsigned hi);
    int unsigned r;
    r = v;
    if (v == 0) begin
      r = 1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: %s at %0t", msg, $time);
    errors++;
  endtask

  task automatic predict_mean(input sample_vec_t px);
    int unsigned      w, h, n, even_w, even_h, slot;
    pair_vec_t        pair;
    logic [SUM_W-1:0] total;
    mean_word_t       word;
    w      = limit_size(width_reg, MAX_WIDTH);
    h      = limit_size(height_reg, MAX_HEIGHT);
    n      = limit_size(chan_reg, MAX_CHANNELS);
    even_w = w & ~32'd1;
    even_h = h & ~32'd1;
    // registers may have moved the image edge under the current position
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) begin
      row_pos = 0;
    end
    if ((col_pos & 1) == 0) begin
      held_left = px;
    end else if (col_pos < even_w) begin
      slot = (col_pos >> 1) % LINE_DEPTH;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        pair[c] = PAIR_W'(held_left[c]) + PAIR_W'(px[c]);
      end
      if ((row_pos & 1) == 0) begin
        line_sums[slot] = pair;
      end else if (row_pos < even_h) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          total = SUM_W'(line_sums[slot][c]) + SUM_W'(pair[c]);
          word.mean[c] = (c < n) ? total[SUM_W-1:2] : '0;
        end
        word.frame_end = (col_pos == even_w - 1) && (row_pos == even_h - 1);
        expected_means.push_back(word);
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
      end
    end
  endtask

  task automatic check_mean(input mean_word_t got);
    mean_word_t want;
    if (expected_means.size() == 0) begin
      report_mismatch($sformatf("mean word %h with nothing expected", got));
    end else begin
      want = expected_means.pop_front();
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        if (got.mean[c] !== want.mean[c]) begin
          report_mismatch($sformatf("mean_ch%0d got %0d expected %0d",
                                    c, got.mean[c], want.mean[c]));
        end
      end
      if (got.frame_end !== want.frame_end) begin
        report_mismatch($sformatf("frame_end got %b expected %b",
                                  got.frame_end, want.frame_end));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      chan_reg   = RESET_CHANNELS;
      held_left  = '0;
      col_pos    = 0;
      row_pos    = 0;
      expected_means.delete();
    end else begin
      // a word leaving now cannot belong to a pixel taken at this edge
      if (means.valid && means.ready) begin
        check_mean({means.mean_ch3, means.mean_ch2, means.mean_ch1, means.mean_ch0,
                    means.frame_end});
      end
      if (pixels.valid && pixels.ready) begin
        predict_mean({pixels.sample_ch3, pixels.sample_ch2, pixels.sample_ch1,
                      pixels.sample_ch0});
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH:         width_reg  = cfg_data;
          REG_HEIGHT:        height_reg = cfg_data;
          REG_CHANNEL_COUNT: chan_reg   = cfg_data[CH_CFG_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_means.size();
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus for the 2x2 box downsampler: directed frames at the field and
// register extremes, a partial row at saturated width, then random frames of
// small size with occasional register changes part way through a frame, under
// varying sender gaps and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bds2x2_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [REG_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bds2x2_pixel_if pixels ();
  bds2x2_mean_if  means ();

  int errors;
  int pending;
  int src_idle_pct;
  int rcv_stall_pct;
  int pixels_sent;

  box_downsample_2x2 u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels),
    .means     (means)
  );

  bds2x2_scoreboard u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels),
    .means     (means),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk) begin
    means.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin src_idle_pct = 54; rcv_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  rcv_stall_pct = 54; end
      IDLE_BOTH:     begin src_idle_pct = 19; rcv_stall_pct = 19; end
      default:       begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
    endcase
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(7))
      0:       s = '0;
      1:       s = '1;
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  // called and returns at a falling edge; valid stays high for a following word
  task automatic push_pixel(input sample_t s0, input sample_t s1,
                            input sample_t s2, input sample_t s3);
    while ($urandom_range(99) < src_idle_pct) begin
      pixels.valid <= 1'b0;
      @(negedge clk);
    end
    pixels.valid      <= 1'b1;
    pixels.sample_ch0 <= s0;
    pixels.sample_ch1 <= s1;
    pixels.sample_ch2 <= s2;
    pixels.sample_ch3 <= s3;
    @(posedge clk);
    while (!pixels.ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic push_random();
    push_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  // stop sending, let every mean word out and the pipeline run dry
  task automatic settle();
    pixels.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                           input logic [CH_CFG_W-1:0] cv);
    cfg_write <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= wv;
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= hv;
    @(negedge clk);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data  <= CFG_W'(cv);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned         w, h;
    logic [CFG_W-1:0]    wreg, hreg;
    logic [CH_CFG_W-1:0] chreg;
    int                  phase;
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = REG_WIDTH;
    cfg_data          = '0;
    pixels.valid      = 1'b0;
    pixels.sample_ch0 = '0;
    pixels.sample_ch1 = '0;
    pixels.sample_ch2 = '0;
    pixels.sample_ch3 = '0;
    pixels_sent       = 0;
    set_idling(IDLE_NONE);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 4x2, all channels, sums up to the largest value
    configure(12'd4, 12'd2, 3'd4);
    push_pixel(8'h00, 8'hFF, 8'h01, 8'h80);
    push_pixel(8'hFF, 8'h00, 8'hFE, 8'h7F);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    settle();
    // odd last column and row dropped, one channel only
    configure(12'd3, 12'd3, 3'd1);
    repeat (9) push_random();
    settle();
    // zero registers act as one: a 1x1 image gives no words
    configure(12'd0, 12'd0, 3'd0);
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    settle();
    // channel count above four saturates
    configure(12'd2, 12'd2, 3'd7);
    push_pixel(8'h01, 8'h02, 8'h03, 8'h04);
    push_pixel(8'h05, 8'h06, 8'h07, 8'h08);
    push_pixel(8'h09, 8'h0A, 8'h0B, 8'h0C);
    push_pixel(8'hFD, 8'hFE, 8'hFF, 8'h00);
    settle();
    // saturated width, part of the first row only
    configure(12'hFFF, 12'd2, 3'd4);
    repeat (300) push_random();
    settle();
    // a 1x1 image puts the position back to the top left corner
    configure(12'd1, 12'd1, 3'd4);
    push_random();

    phase = 0;
    while (pixels_sent < 1850) begin
      settle();
      set_idling(idle_mode_e'(phase % 4));
      w     = ($urandom_range(3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      h     = $urandom_range(1, 8);
      wreg  = (w == 1 && $urandom_range(1) == 1) ? '0 : CFG_W'(w);
      hreg  = (h == 1 && $urandom_range(1) == 1) ? '0 : CFG_W'(h);
      chreg = CH_CFG_W'($urandom_range(7));
      configure(wreg, hreg, chreg);
      repeat ($urandom_range(1, 3) * w * h) push_random();
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, w * h)) push_random();
        settle();
        case ($urandom_range(2))
          // only narrowing: a wider line would read slots not filled this frame
          0:       wreg = CFG_W'($urandom_range(1, w));
          1:       hreg = ($urandom_range(1) == 1) ? 12'hFFF : CFG_W'($urandom_range(0, 12));
          default: chreg = CH_CFG_W'($urandom_range(7));
        endcase
        configure(wreg, hreg, chreg);
        repeat ($urandom_range(1, 40)) push_random();
        settle();
        // a 1x1 image puts the position back to the top left corner
        configure(12'd1, 12'd1, chreg);
        push_random();
      end
      phase++;
    end

    pixels.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bds2x2_pkg.sv
rtl/bds2x2_stream_if.sv
rtl/box_downsample_2x2.sv
rtl/bds2x2_checker.sv
bench/bds2x2_checker.sv
bench/tb.sv
